### sv/ste_pkg.sv
`default_nettype none

package ste_pkg;

    // Field widths of the entry words and of a tile command
    localparam int CODE_W = 14;
    localparam int COL_W  = 4;
    localparam int SX_W   = 10;
    localparam int SY_W   = 11;
    localparam int SEG_W  = 3;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One visible sprite entry, ready for expansion into tile commands
    typedef struct packed {
        logic [CODE_W-1:0] base;      // tile code with low segment bits cleared
        logic [SEG_W-1:0]  top;       // number of segments minus one
        logic              entry_fy;  // entry's own flip y, orders the codes
        logic              flip_scr;  // stack downward when set
        logic [COL_W-1:0]  colour;
        logic              fx;
        logic              fy;
        logic [SX_W-1:0]   x;
        logic [SY_W-1:0]   y;         // position of segment zero
    } entry_t;

endpackage : ste_pkg

`default_nettype wire

### sv/sprite_entry_tile_expander.sv
// Sprite entry tile expander.
//
// Input channel (in_valid/in_ready) takes one sprite entry word set:
// attr_word, code_word, pos_word and frame_odd. Entries with a zero tile
// code, or flashing entries on an odd frame, are taken and dropped.
// Each visible entry gives 1, 2, 4 or 8 tile commands on the output
// channel (out_valid/out_ready), far end of the stack first, last set on the final one.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the screen
// flip bit; it is always ready and should change only while the block is idle.
//
// The first command of an entry passes through the queue slot, the sequencer's
// entry register and the output register. Throughput: one command per cycle
// while the receiver takes every word; the segment sequencer in the back end
// sets this rate. A dropped entry never enters the queue.
// A two-word queue sits between the classifying front and the sequencer.
// When the receiver stalls, the output word holds and the sequencer waits;
// the front keeps taking entries until the queue is full.
// Reset clears the queue, the sequencer and the screen flip bit.

`default_nettype none

module sprite_entry_tile_expander
    import ste_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       attr_word,
    input  wire logic [15:0]       code_word,
    input  wire logic [15:0]       pos_word,
    input  wire logic              frame_odd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CODE_W-1:0]      tile_code,
    output logic [COL_W-1:0]       colour,
    output logic                   flip_x,
    output logic                   flip_y,
    output logic signed [SX_W-1:0] screen_x,
    output logic signed [SY_W-1:0] screen_y,
    output logic                   last
);

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    ste_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .attr_word  (attr_word),
        .code_word  (code_word),
        .pos_word   (pos_word),
        .frame_odd  (frame_odd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    ste_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ste_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tile_code  (tile_code),
        .colour     (colour),
        .flip_x     (flip_x),
        .flip_y     (flip_y),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .last       (last)
    );

endmodule : sprite_entry_tile_expander

`default_nettype wire

### sv/ste_front.sv
`default_nettype none

module ste_front
    import ste_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] attr_word,
    input  wire logic [15:0] code_word,
    input  wire logic [15:0] pos_word,
    input  wire logic        frame_odd,
    output logic             push_valid,
    input  wire logic        push_ready,
    output entry_t           push_entry
);

    logic              flip_screen_reg;
    logic              flip_screen_next;
    logic [CODE_W-1:0] code;
    logic              hidden;
    logic [SEG_W-1:0]  top;
    logic [SX_W-1:0]   x9;
    logic [SY_W-1:0]   y9;

    // Hold the screen flip register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        flip_screen_next = flip_screen_reg;
        if (cfg_valid)
        begin
            flip_screen_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_screen_reg <= 1'b0;
        end
        else
        begin
            flip_screen_reg <= flip_screen_next;
        end
    end

    // Classify: drop empty entries and flashing entries on odd frames
    assign code     = code_word[CODE_W-1:0];
    assign hidden   = (code == '0) || (attr_word[12] && frame_odd);
    assign in_ready = push_ready;
    assign push_valid = in_valid && !hidden;

    // Decode the segment count
    always_comb
    begin
        unique case (attr_word[10:9])
            2'd0: top = 3'd0;
            2'd1: top = 3'd1;
            2'd2: top = 3'd3;
            default: top = 3'd7;
        endcase
    end

    // Wrap the 9-bit positions to signed values
    assign x9 = (pos_word[8:0] >= 9'd320) ? {1'b1, pos_word[8:0]} : {1'b0, pos_word[8:0]};
    assign y9 = {{2{attr_word[8]}}, attr_word[8:0]};

    // Build the entry word for the back end
    always_comb
    begin
        push_entry.base     = code & ~{{(CODE_W-SEG_W){1'b0}}, top};
        push_entry.top      = top;
        push_entry.entry_fy = attr_word[14];
        push_entry.flip_scr = flip_screen_reg;
        push_entry.colour   = pos_word[12:9];
        push_entry.fx       = attr_word[13] ^ flip_screen_reg;
        push_entry.fy       = attr_word[14] ^ flip_screen_reg;
        if (flip_screen_reg)
        begin
            push_entry.x = x9;
            push_entry.y = y9;
        end
        else
        begin
            push_entry.x = 10'd304 - x9;
            push_entry.y = 11'd240 - y9;
        end
    end

endmodule : ste_front

`default_nettype wire

### sv/ste_queue.sv
`default_nettype none

module ste_queue
    import ste_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire entry_t push_entry,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output entry_t      pop_entry
);

    entry_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule : ste_queue

`default_nettype wire

### sv/ste_back.sv
`default_nettype none

module ste_back
    import ste_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    output logic              pop_ready,
    input  wire entry_t       pop_entry,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [CODE_W-1:0] tile_code,
    output logic [COL_W-1:0]  colour,
    output logic              flip_x,
    output logic              flip_y,
    output logic [SX_W-1:0]   screen_x,
    output logic [SY_W-1:0]   screen_y,
    output logic              last
);

    entry_t            cur_reg;
    logic              active_reg;
    logic              active_next;
    logic [SEG_W-1:0]  seg_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] tile_code_reg;
    logic [COL_W-1:0]  colour_reg;
    logic              flip_x_reg;
    logic              flip_y_reg;
    logic [SX_W-1:0]   screen_x_reg;
    logic [SY_W-1:0]   screen_y_reg;
    logic              last_reg;
    logic              adv;
    logic              seg_done;
    logic              do_pop;
    logic [SEG_W-1:0]  code_off;
    logic [SY_W-1:0]   y_off;
    logic [CODE_W-1:0] tile_calc;
    logic [SY_W-1:0]   y_calc;

    // Emit one segment whenever the output register is free
    assign adv       = active_reg && (!out_valid_reg || out_ready);
    assign seg_done  = (seg_reg == '0);
    assign pop_ready = !active_reg || (adv && seg_done);
    assign do_pop    = pop_valid && pop_ready;

    // Tile offset: count up or down by the entry's flip y; base has clear low bits
    assign code_off  = cur_reg.entry_fy ? seg_reg : (cur_reg.top ^ seg_reg);
    assign tile_calc = cur_reg.base | {{(CODE_W-SEG_W){1'b0}}, code_off};

    // Stack sixteen lines per segment, up or down by screen flip
    assign y_off  = {{(SY_W-SEG_W-4){1'b0}}, seg_reg, 4'b0000};
    assign y_calc = cur_reg.flip_scr ? (cur_reg.y + y_off) : (cur_reg.y - y_off);

    always_comb
    begin
        active_next = active_reg;
        if (do_pop)
        begin
            active_next = 1'b1;
        end
        else if (adv && seg_done)
        begin
            active_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new entry, or step to the next segment
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            cur_reg <= pop_entry;
            seg_reg <= pop_entry.top;
        end
        else if (adv)
        begin
            seg_reg <= seg_reg - 1'b1;
        end
    end

    // Capture the tile command
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tile_code_reg <= tile_calc;
            colour_reg    <= cur_reg.colour;
            flip_x_reg    <= cur_reg.fx;
            flip_y_reg    <= cur_reg.fy;
            screen_x_reg  <= cur_reg.x;
            screen_y_reg  <= y_calc;
            last_reg      <= seg_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign tile_code = tile_code_reg;
    assign colour    = colour_reg;
    assign flip_x    = flip_x_reg;
    assign flip_y    = flip_y_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;
    assign last      = last_reg;

endmodule : ste_back

`default_nettype wire

### sv/ste_checker.sv
`default_nettype none

module ste_checker
    import ste_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CODE_W-1:0] tile_code,
    input wire logic [COL_W-1:0]  colour,
    input wire logic              flip_x,
    input wire logic              flip_y,
    input wire logic [SX_W-1:0]   screen_x,
    input wire logic [SY_W-1:0]   screen_y,
    input wire logic              last
);

    // A stalled word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word withdrawn while stalled");

    // Segments of one entry follow without a gap and share x, colour and flips
    a_seg_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && $stable(screen_x)
            && $stable(colour) && $stable(flip_x) && $stable(flip_y))
        else $error("segment of an entry missing or changed attributes");

    // Consecutive segments sit sixteen lines apart
    a_seg_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            ((screen_y - $past(screen_y)) == SY_W'(16))
            || ((screen_y - $past(screen_y)) == SY_W'(-16)))
        else $error("segment pitch is not sixteen lines");

    // Consecutive segments use neighbouring tile codes
    a_seg_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            ((tile_code - $past(tile_code)) == CODE_W'(1))
            || ((tile_code - $past(tile_code)) == CODE_W'(-1)))
        else $error("segment tile codes are not adjacent");

endmodule : ste_checker

bind sprite_entry_tile_expander ste_checker u_ste_checker (.*);

`default_nettype wire

### tb/sv/tb_sprite_entry_tile_expander.sv
`timescale 1ns / 1ps

module tb_sprite_entry_tile_expander;
    import ste_pkg::*;

    // One tile draw command as seen on the output channel
    typedef struct packed {
        logic [CODE_W-1:0] tile_code;
        logic [COL_W-1:0]  colour;
        logic              fx;
        logic              fy;
        logic [SX_W-1:0]   sx;
        logic [SY_W-1:0]   sy;
        logic              last;
    } tile_cmd_t;

    // How a directed row is checked: by the predictor, as giving no command, or against typed values
    typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_CMD, ROW_ONE_CMD} row_kind_t;

    typedef struct packed {
        logic [15:0] attr;
        logic [15:0] code;
        logic [15:0] pos;
        logic        odd;
        logic        flip;
        row_kind_t   kind;
        tile_cmd_t   cmd;
    } dir_row_t;

    localparam tile_cmd_t NO_TYPED = '0;
    localparam int N_DIR = 21;
    localparam int N_RAND_PHASE = 40;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD_CYCLES = 60;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // plain one-tile sprite straight after reset
        '{16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b0, ROW_ONE_CMD,
          '{14'h0001, 4'h0, 1'b0, 1'b0, 10'd304, 11'd240, 1'b1}},
        // zero tile code, with and without ignored upper code bits
        '{16'h7fff, 16'h0000, 16'hffff, 1'b0, 1'b0, ROW_NO_CMD, NO_TYPED},
        '{16'h0600, 16'hc000, 16'h1234, 1'b1, 1'b0, ROW_NO_CMD, NO_TYPED},
        // flashing sprite hidden on an odd frame, shown on an even one
        '{16'h1000, 16'h0005, 16'h0000, 1'b1, 1'b0, ROW_NO_CMD, NO_TYPED},
        '{16'h1000, 16'h0005, 16'h0000, 1'b0, 1'b0, ROW_ONE_CMD,
          '{14'h0005, 4'h0, 1'b0, 1'b0, 10'd304, 11'd240, 1'b1}},
        // largest code, colour and wrapped positions
        '{16'h61ff, 16'h3fff, 16'h1fff, 1'b0, 1'b0, ROW_ONE_CMD,
          '{14'h3fff, 4'hf, 1'b1, 1'b1, 10'd305, 11'd241, 1'b1}},
        '{16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0, ROW_PREDICT, NO_TYPED},
        // x either side of the wrap point, y either side of its wrap point
        '{16'h0200, 16'h0123, 16'h013f, 1'b0, 1'b0, ROW_PREDICT, NO_TYPED},
        '{16'h0400, 16'h2aaa, 16'h0140, 1'b0, 1'b0, ROW_PREDICT, NO_TYPED},
        '{16'h06ff, 16'h1555, 16'h0e00, 1'b0, 1'b0, ROW_PREDICT, NO_TYPED},
        '{16'h4100, 16'h0007, 16'h0100, 1'b0, 1'b0, ROW_PREDICT, NO_TYPED},
        // eight-tile stacks, codes counting down and up
        '{16'h4600, 16'h00ff, 16'h0000, 1'b0, 1'b0, ROW_PREDICT, NO_TYPED},
        '{16'h2600, 16'h0101, 16'h1e1f, 1'b0, 1'b0, ROW_PREDICT, NO_TYPED},
        '{16'h7fff, 16'h3fff, 16'hffff, 1'b1, 1'b0, ROW_NO_CMD, NO_TYPED},
        // screen flipped
        '{16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b1, ROW_ONE_CMD,
          '{14'h0001, 4'h0, 1'b1, 1'b1, 10'd0, 11'd0, 1'b1}},
        '{16'h61ff, 16'h3fff, 16'h1fff, 1'b0, 1'b1, ROW_ONE_CMD,
          '{14'h3fff, 4'hf, 1'b0, 1'b0, 10'h3ff, 11'h7ff, 1'b1}},
        '{16'h0600, 16'h0009, 16'h0140, 1'b0, 1'b1, ROW_PREDICT, NO_TYPED},
        '{16'h4400, 16'h3ffd, 16'h013f, 1'b0, 1'b1, ROW_PREDICT, NO_TYPED},
        '{16'h1200, 16'h0002, 16'h0a00, 1'b1, 1'b1, ROW_NO_CMD, NO_TYPED},
        '{16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b1, ROW_PREDICT, NO_TYPED},
        '{16'h0000, 16'h4000, 16'h0000, 1'b0, 1'b1, ROW_NO_CMD, NO_TYPED}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] attr_word = '0;
    logic [15:0] code_word = '0;
    logic [15:0] pos_word = '0;
    logic frame_odd = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CODE_W-1:0] tile_code;
    logic [COL_W-1:0] colour;
    logic flip_x;
    logic flip_y;
    logic signed [SX_W-1:0] screen_x;
    logic signed [SY_W-1:0] screen_y;
    logic last;

    tile_cmd_t pending_cmds[$];
    logic screen_flipped = 1'b0;
    bit no_idle = 1'b0;
    bit long_hold = 1'b0;
    int n_errors = 0;
    int n_cmds = 0;
    int n_entries = 0;
    int n_visible = 0;

    sprite_entry_tile_expander u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .attr_word (attr_word),
        .code_word (code_word),
        .pos_word  (pos_word),
        .frame_odd (frame_odd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tile_code (tile_code),
        .colour    (colour),
        .flip_x    (flip_x),
        .flip_y    (flip_y),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .last      (last)
    );

    always #2 clk = ~clk;

    // Expand one entry into the tile commands it should give
    function automatic void expand_entry(input logic [15:0] attr, input logic [15:0] code_w,
                                         input logic [15:0] pos, input logic odd);
        tile_cmd_t c;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] base;
        int top;
        int x;
        int y;
        int step;
        code = code_w[CODE_W-1:0];
        if (code == '0 || (attr[12] && odd))
            return;
        n_visible++;
        top = (1 << attr[10:9]) - 1;
        x = int'(pos[8:0]);
        y = int'(attr[8:0]);
        if (x >= 320)
            x -= 512;
        if (y >= 256)
            y -= 512;
        // unflipped screen mirrors both axes and stacks upward
        if (!screen_flipped)
        begin
            x = 304 - x;
            y = 240 - y;
            step = -16;
        end
        else
            step = 16;
        base = code & ~CODE_W'(top);
        c.colour = pos[12:9];
        c.fx = attr[13] ^ screen_flipped;
        c.fy = attr[14] ^ screen_flipped;
        c.sx = SX_W'(x);
        for (int m = top; m >= 0; m--)
        begin
            c.tile_code = attr[14] ? base + CODE_W'(m) : base + CODE_W'(top - m);
            c.sy = SY_W'(y + step * m);
            c.last = (m == 0);
            pending_cmds.push_back(c);
        end
    endfunction

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endfunction

    // Offer one entry after a random gap, hold it until taken
    task automatic send_entry(input logic [15:0] attr, input logic [15:0] code,
                              input logic [15:0] pos, input logic odd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        attr_word <= attr;
        code_word <= code;
        pos_word <= pos;
        frame_odd <= odd;
        do @(posedge clk); while (!in_ready);
        n_entries++;
    endtask

    // Drain the block, let any dropped entry clear, then write the flip bit
    task automatic set_screen_flip(input logic v);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        screen_flipped = v;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each taken word with the oldest expected command
    always @(posedge clk)
    begin : cmd_check
        tile_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_cmds++;
            if (pending_cmds.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected tile command, code %h x %0d y %0d last %b",
                         $time, tile_code, screen_x, screen_y, last);
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("tile_code", want.tile_code, tile_code);
                check_field("colour", want.colour, colour);
                check_field("flip_x", want.fx, flip_x);
                check_field("flip_y", want.fy, flip_y);
                check_field("screen_x", int'($signed(want.sx)), int'(screen_x));
                check_field("screen_y", int'($signed(want.sy)), int'(screen_y));
                check_field("last", want.last, last);
            end
        end
    end

    initial
    begin
        logic [15:0] attr;
        logic [15:0] code;
        logic [15:0] pos;
        logic odd;
        int sel;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_screen_flip(1'b0);

        // Directed rows
        for (int r = 0; r < N_DIR; r++)
        begin
            if (DIR_ROWS[r].flip != screen_flipped)
                set_screen_flip(DIR_ROWS[r].flip);
            send_entry(DIR_ROWS[r].attr, DIR_ROWS[r].code, DIR_ROWS[r].pos, DIR_ROWS[r].odd);
            case (DIR_ROWS[r].kind)
                ROW_ONE_CMD:
                begin
                    pending_cmds.push_back(DIR_ROWS[r].cmd);
                    n_visible++;
                end
                ROW_PREDICT:
                    expand_entry(DIR_ROWS[r].attr, DIR_ROWS[r].code, DIR_ROWS[r].pos,
                                 DIR_ROWS[r].odd);
                default:
                    ;
            endcase
        end

        // Random phases: flip off and on, one without idling, one with a long hold
        for (int p = 0; p < 4; p++)
        begin
            set_screen_flip(p[0]);
            no_idle = (p == 1);
            long_hold = (p == 2);
            for (int i = 0; i < N_RAND_PHASE; i++)
            begin
                sel = $urandom_range(0, 9);
                attr = 16'($urandom);
                code = 16'($urandom);
                pos = 16'($urandom);
                odd = 1'($urandom);
                if (sel == 0)
                    code[CODE_W-1:0] = '0;
                else if (code[CODE_W-1:0] == '0)
                    code[0] = 1'b1;
                if (sel == 1)
                begin
                    attr[12] = 1'b1;
                    odd = 1'b1;
                end
                send_entry(attr, code, pos, odd);
                expand_entry(attr, code, pos, odd);
            end
        end
        no_idle = 1'b0;

        // Wait for the tail, then allow stray words time to show
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d sprite entries (%0d visible), checked %0d tile commands",
                 n_entries, n_visible, n_cmds);
        $display("Screen flip exercised both ways, with idle-free and long-stall phases");
        if (n_errors == 0)
            $display("tb_sprite_entry_tile_expander OK");
        else
            $display("tb_sprite_entry_tile_expander NOT OK");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d tile commands outstanding", pending_cmds.size());
        $display("tb_sprite_entry_tile_expander NOT OK");
        $finish;
    end

endmodule
